@@ src/bls_pkg.sv @@
// bls_pkg: shared types and codes for the bounded list store
// operation and status codes, result item layout
// no dependencies
package bls_pkg;

    // operation codes carried on the input tuser
    localparam logic [2:0] OP_ADD_UNIQUE = 3'd0;
    localparam logic [2:0] OP_APPEND     = 3'd1;
    localparam logic [2:0] OP_POP        = 3'd2;
    localparam logic [2:0] OP_REPLACE    = 3'd3;
    localparam logic [2:0] OP_SWAP       = 3'd4;
    localparam logic [2:0] OP_CLEAR      = 3'd5;

    // status codes carried on the output tuser
    localparam logic [2:0] ST_DONE       = 3'd0;
    localparam logic [2:0] ST_PRESENT    = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
    localparam logic [2:0] ST_FULL       = 3'd3;
    localparam logic [2:0] ST_EMPTY      = 3'd4;
    localparam logic [2:0] ST_BAD_POS    = 3'd5;

    // fixed field widths of the stream items
    localparam int VAL_W   = 32;
    localparam int POS_W   = 6;
    localparam int IDX_W   = 6;
    localparam int TOTAL_W = 7;

    // one result item as produced by the controller
    typedef struct packed {
        logic [2:0]         status;
        logic [IDX_W-1:0]   found_index;
        logic [VAL_W-1:0]   popped_value;
        logic [TOTAL_W-1:0] entry_total;
    } t_result;

endpackage

@@ src/bounded_list_store.sv @@
// bounded_list_store: a list of up to DEPTH signed 32-bit entries with a count
// Input items carry an operation on s tuser and key, new value and position on
// s tdata; each accepted item yields exactly one result item on the m channel.
// Operations: add unique, append, pop, replace all, swap by value, clear.
// The scans read the entry memory one entry a cycle through its single read
// port; a new item is taken once the current one has handed its result to
// the output register.
// A result waiting in the output register does not block the next item; a
// stalled receiver holds the result stable and stalls the block only when a
// second result is ready behind it.
// Reset clears the entry count and all handshake state; the
// entry memory is not cleared, since no slot at or above the count is read.
module bounded_list_store
    import bls_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,  // key [31:0], new_value [63:32], position [69:64]
    input  logic [2:0]  i_s_axis_tuser,  // operation [2:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,  // found_index [5:0], popped_value [37:6],
                                         // entry_total [44:38]
    output logic [2:0]  o_m_axis_tuser   // status [2:0]
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic             res_valid;
    logic             res_ready;
    t_result          res;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [VAL_W-1:0] wdata;
    logic             re;
    logic [AW-1:0]    raddr;
    logic [VAL_W-1:0] rdata;

    logic             r_out_valid;
    t_result          r_out;

    bls_ctrl #(
        .DEPTH(DEPTH),
        .AW   (AW),
        .CW   (CW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_s_axis_tvalid),
        .o_req_ready    (o_s_axis_tready),
        .i_req_op       (i_s_axis_tuser),
        .i_req_key      (i_s_axis_tdata[31:0]),
        .i_req_new_value(i_s_axis_tdata[63:32]),
        .i_req_position (i_s_axis_tdata[69:64]),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_res          (res),
        .o_we           (we),
        .o_waddr        (waddr),
        .o_wdata        (wdata),
        .o_re           (re),
        .o_raddr        (raddr),
        .i_rdata        (rdata)
    );

    bls_mem #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // output register, refilled as it drains
    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.status;
    assign o_m_axis_tdata  = {3'b000, r_out.entry_total, r_out.popped_value,
                              r_out.found_index};

endmodule

@@ src/bls_mem.sv @@
// bls_mem: entry storage of the bounded list store
// one write port, one read port with registered read data
// depends on bls_pkg
module bls_mem
    import bls_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [VAL_W-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [VAL_W-1:0] o_rdata
);

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_data <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rd_data;

endmodule

@@ src/bls_ctrl.sv @@
// bls_ctrl: operation sequencer of the bounded list store
// holds the entry count, scans the memory one entry a cycle, builds results
// depends on bls_pkg and drives the ports of bls_mem
module bls_ctrl
    import bls_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int CW    = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // request side
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  logic [2:0]       i_req_op,
    input  logic [VAL_W-1:0] i_req_key,
    input  logic [VAL_W-1:0] i_req_new_value,
    input  logic [POS_W-1:0] i_req_position,
    // result side
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output t_result          o_res,
    // memory ports
    output logic             o_we,
    output logic [AW-1:0]    o_waddr,
    output logic [VAL_W-1:0] o_wdata,
    output logic             o_re,
    output logic [AW-1:0]    o_raddr,
    input  logic [VAL_W-1:0] i_rdata
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_SW_RD  = 3'd3;
    localparam logic [2:0] S_SW_WR1 = 3'd4;
    localparam logic [2:0] S_SW_WR2 = 3'd5;
    localparam logic [2:0] S_POP    = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [2:0]       r_state, n_state;
    logic [2:0]       r_op, n_op;
    logic [VAL_W-1:0] r_key, n_key;
    logic [VAL_W-1:0] r_nv, n_nv;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_addr, n_addr;
    logic             r_chk, n_chk;
    logic [AW-1:0]    r_chk_idx, n_chk_idx;
    logic [AW-1:0]    r_hit_idx, n_hit_idx;
    logic             r_any, n_any;
    logic [2:0]       r_status, n_status;
    logic [AW-1:0]    r_idx, n_idx;
    logic [VAL_W-1:0] r_pop, n_pop;

    logic                  match;
    logic                  issue;
    logic                  full;
    logic                  pos_bad;
    logic [CW+POS_W-1:0]   pos_ext;
    logic [CW+POS_W-1:0]   cnt_ext;
    logic [AW+IDX_W-1:0]   idx_ext;
    logic [CW+TOTAL_W-1:0] total_ext;
    logic [CW-1:0]         count_dec;

    assign match     = r_chk && (i_rdata == r_key);
    assign issue     = r_addr < r_count;
    assign full      = r_count == FULL_CNT;
    assign pos_ext   = {{CW{1'b0}}, r_pos};
    assign cnt_ext   = {{POS_W{1'b0}}, r_count};
    assign pos_bad   = pos_ext >= cnt_ext;
    assign count_dec = r_count - 1'b1;

    // result fields masked to the stream widths
    assign idx_ext   = {{IDX_W{1'b0}}, r_idx};
    assign total_ext = {{TOTAL_W{1'b0}}, r_count};

    assign o_req_ready = r_state == S_IDLE;
    assign o_res_valid = r_state == S_DONE;
    assign o_res       = '{status:       r_status,
                           found_index:  idx_ext[IDX_W-1:0],
                           popped_value: r_pop,
                           entry_total:  total_ext[TOTAL_W-1:0]};

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_key     = r_key;
        n_nv      = r_nv;
        n_pos     = r_pos;
        n_count   = r_count;
        n_addr    = r_addr;
        n_chk     = r_chk;
        n_chk_idx = r_chk_idx;
        n_hit_idx = r_hit_idx;
        n_any     = r_any;
        n_status  = r_status;
        n_idx     = r_idx;
        n_pop     = r_pop;
        o_we      = 1'b0;
        o_waddr   = '0;
        o_wdata   = '0;
        o_re      = 1'b0;
        o_raddr   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_op     = i_req_op;
                    n_key    = i_req_key;
                    n_nv     = i_req_new_value;
                    n_pos    = i_req_position;
                    n_status = ST_DONE;
                    n_idx    = '0;
                    n_pop    = '0;
                    n_state  = S_EXEC;
                end
            end

            S_EXEC: begin
                n_addr  = '0;
                n_chk   = 1'b0;
                n_any   = 1'b0;
                n_state = S_DONE;
                case (r_op)
                    OP_ADD_UNIQUE, OP_REPLACE: begin
                        n_state = S_SCAN;
                    end
                    OP_APPEND: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            o_we    = 1'b1;
                            o_waddr = r_count[AW-1:0];
                            o_wdata = r_key;
                            n_idx   = r_count[AW-1:0];
                            n_count = r_count + 1'b1;
                        end
                    end
                    OP_POP: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            o_re    = 1'b1;
                            o_raddr = count_dec[AW-1:0];
                            n_count = count_dec;
                            n_state = S_POP;
                        end
                    end
                    OP_SWAP: begin
                        if (pos_bad) begin
                            n_status = ST_BAD_POS;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    OP_CLEAR: begin
                        n_count = '0;
                    end
                    default: begin
                        n_status = ST_DONE;
                    end
                endcase
            end

            S_SCAN: begin
                if ((r_op != OP_REPLACE) && match) begin
                    // first match ends a search
                    n_hit_idx = r_chk_idx;
                    n_chk     = 1'b0;
                    if (r_op == OP_ADD_UNIQUE) begin
                        n_status = ST_PRESENT;
                        n_idx    = r_chk_idx;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_SW_RD;
                    end
                end else begin
                    // replace all rewrites each match as it streams past
                    if (match) begin
                        o_we    = 1'b1;
                        o_waddr = r_chk_idx;
                        o_wdata = r_nv;
                        n_any   = 1'b1;
                    end
                    if (issue) begin
                        o_re      = 1'b1;
                        o_raddr   = r_addr[AW-1:0];
                        n_chk_idx = r_addr[AW-1:0];
                        n_addr    = r_addr + 1'b1;
                        n_chk     = 1'b1;
                    end else begin
                        n_chk = 1'b0;
                    end
                    // nothing in flight and nothing left to read
                    if (!r_chk && !issue) begin
                        n_state = S_DONE;
                        case (r_op)
                            OP_REPLACE: begin
                                n_status = r_any ? ST_DONE : ST_NOT_FOUND;
                            end
                            OP_ADD_UNIQUE: begin
                                if (full) begin
                                    n_status = ST_FULL;
                                end else begin
                                    o_we    = 1'b1;
                                    o_waddr = r_count[AW-1:0];
                                    o_wdata = r_key;
                                    n_idx   = r_count[AW-1:0];
                                    n_count = r_count + 1'b1;
                                end
                            end
                            default: begin
                                n_status = ST_NOT_FOUND;
                            end
                        endcase
                    end
                end
            end

            S_SW_RD: begin
                o_re    = 1'b1;
                o_raddr = pos_ext[AW-1:0];
                n_state = S_SW_WR1;
            end

            S_SW_WR1: begin
                // entry at the position moves to the matching slot
                o_we    = 1'b1;
                o_waddr = r_hit_idx;
                o_wdata = i_rdata;
                n_state = S_SW_WR2;
            end

            S_SW_WR2: begin
                o_we    = 1'b1;
                o_waddr = pos_ext[AW-1:0];
                o_wdata = r_key;
                n_idx   = r_hit_idx;
                n_state = S_DONE;
            end

            S_POP: begin
                n_pop   = i_rdata;
                n_state = S_DONE;
            end

            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_chk   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_chk   <= n_chk;
        end
    end

    // operands and result payload
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_key     <= n_key;
        r_nv      <= n_nv;
        r_pos     <= n_pos;
        r_addr    <= n_addr;
        r_chk_idx <= n_chk_idx;
        r_hit_idx <= n_hit_idx;
        r_any     <= n_any;
        r_status  <= n_status;
        r_idx     <= n_idx;
        r_pop     <= n_pop;
    end

endmodule

@@ src/bls_checker.sv @@
// bls_checker: port-level checks for bounded_list_store
// watches only the top-level ports; bound in below
// depends on bls_pkg
module bls_checker
    import bls_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic [2:0]  o_m_axis_tuser
);

    // a stalled result item holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result item changed while stalled");

    // no result item right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // one item at a time: the input closes right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input ready right after an accepted item");

    // only a successful operation may return a popped value
    a_pop_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != ST_DONE) |->
            o_m_axis_tdata[37:6] == '0)
        else $error("popped value on a refused operation");

    // an empty pop reports an empty list and no slot
    a_empty_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == ST_EMPTY) |->
            (o_m_axis_tdata[44:38] == '0) && (o_m_axis_tdata[5:0] == '0))
        else $error("empty status with entries or slot");

endmodule

bind bounded_list_store bls_checker u_bls_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_s_axis_tvalid(i_s_axis_tvalid),
    .o_s_axis_tready(o_s_axis_tready),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata),
    .o_m_axis_tuser (o_m_axis_tuser)
);

@@ tb/bounded_list_store_test.sv @@
// bounded_list_store_test: self-checking stream testbench for the bounded list store
// directed and phased random operations, a cycle-free predictor, randomized idling on both sides
// depends on bls_pkg and bounded_list_store
`timescale 1ns / 100ps

module bounded_list_store_test;
    import bls_pkg::*;

    localparam int LIST_DEPTH     = 64;
    localparam int TOTAL_ITEMS    = 850;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 80;

    // operation codes the block leaves unused
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} mix_t;

    // one input item as the list sees it
    typedef struct packed {
        logic [2:0]       op;
        logic [VAL_W-1:0] key;
        logic [VAL_W-1:0] new_value;
        logic [POS_W-1:0] position;
    } list_op_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;   // key [31:0], new_value [63:32], position [69:64]
    logic [2:0]  s_tuser = '0;   // operation [2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // found_index [5:0], popped_value [37:6], entry_total [44:38]
    logic [2:0]  m_tuser;        // status [2:0]

    // predicted list contents and count
    logic [VAL_W-1:0] list_mem [LIST_DEPTH];
    int               list_count = 0;

    list_op_t pending_ops [$];
    t_result  expected_results [$];
    list_op_t cur_item = '0;
    logic     offered = 1'b0;
    int       send_wait = 0;
    int       recv_wait = 0;
    bit       send_burst = 1'b0;
    bit       recv_burst = 1'b0;
    int       fail_count = 0;
    int       items_accepted = 0;
    int       results_checked = 0;
    int       status_seen [8];
    int       peak_total = 0;
    int       stall_cycles = 0;

    bounded_list_store #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tuser (m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // apply one operation to the predicted list and return its result item
    function automatic t_result apply_op(list_op_t it);
        t_result r;
        logic    hit;
        int      first;
        int      i;
        r = '0;
        hit = 1'b0;
        first = 0;
        for (i = 0; i < list_count; i++) begin
            if (!hit && list_mem[i] == it.key) begin
                hit = 1'b1;
                first = i;
            end
        end
        r.status = ST_DONE;
        case (it.op)
            OP_ADD_UNIQUE: begin
                if (hit) begin
                    r.status = ST_PRESENT;
                    r.found_index = IDX_W'(first);
                end else if (list_count >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    r.found_index = IDX_W'(list_count);
                    list_mem[list_count] = it.key;
                    list_count++;
                end
            end
            OP_APPEND: begin
                if (list_count >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    r.found_index = IDX_W'(list_count);
                    list_mem[list_count] = it.key;
                    list_count++;
                end
            end
            OP_POP: begin
                if (list_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    list_count--;
                    r.popped_value = list_mem[list_count];
                end
            end
            OP_REPLACE: begin
                r.status = ST_NOT_FOUND;
                for (i = 0; i < list_count; i++) begin
                    if (list_mem[i] == it.key) begin
                        list_mem[i] = it.new_value;
                        r.status = ST_DONE;
                    end
                end
            end
            OP_SWAP: begin
                // range check comes before the search
                if (it.position >= list_count) begin
                    r.status = ST_BAD_POS;
                end else if (!hit) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    list_mem[first] = list_mem[it.position];
                    list_mem[it.position] = it.key;
                    r.found_index = IDX_W'(first);
                end
            end
            OP_CLEAR: list_count = 0;
            default: ;
        endcase
        r.entry_total = TOTAL_W'(list_count);
        return r;
    endfunction

    function automatic int draw_wait(bit burst);
        return burst ? 0 : $urandom_range(0, 14);
    endfunction

    // values mostly from a small pool so that searches hit, sometimes fully random
    function automatic logic [VAL_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 3)
            return $urandom;
        case ($urandom_range(0, 11))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'h0000_0001;
            5: return 32'hAAAA_AAAA;
            6: return 32'h5555_5555;
            7: return 32'h0000_00FF;
            8: return 32'h1234_5678;
            9: return 32'hDEAD_0001;
            10: return 32'h0F0F_0F0F;
            default: return 32'hFFFF_FF00;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        return ($urandom_range(0, 9) < 4) ? POS_W'($urandom_range(0, 63))
                                          : POS_W'($urandom_range(0, 15));
    endfunction

    // operation mix per phase: fill grows the list, drain shrinks it
    function automatic logic [2:0] pick_op(mix_t mix);
        int roll;
        roll = $urandom_range(0, 99);
        case (mix)
            PH_FILL: begin
                if (roll < 45) return OP_APPEND;
                if (roll < 70) return OP_ADD_UNIQUE;
                if (roll < 80) return OP_SWAP;
                if (roll < 90) return OP_REPLACE;
                if (roll < 98) return OP_POP;
                return (roll < 99) ? OP_SPARE_A : OP_SPARE_B;
            end
            PH_DRAIN: begin
                if (roll < 50) return OP_POP;
                if (roll < 60) return OP_ADD_UNIQUE;
                if (roll < 70) return OP_APPEND;
                if (roll < 80) return OP_SWAP;
                if (roll < 93) return OP_REPLACE;
                if (roll < 97) return OP_CLEAR;
                return (roll < 98) ? OP_SPARE_A : OP_SPARE_B;
            end
            default: begin
                if (roll < 20) return OP_ADD_UNIQUE;
                if (roll < 40) return OP_APPEND;
                if (roll < 60) return OP_POP;
                if (roll < 78) return OP_SWAP;
                if (roll < 95) return OP_REPLACE;
                if (roll < 98) return OP_CLEAR;
                return (roll < 99) ? OP_SPARE_A : OP_SPARE_B;
            end
        endcase
    endfunction

    task automatic queue_op(logic [2:0] op, logic [VAL_W-1:0] key, logic [VAL_W-1:0] nv,
                            logic [POS_W-1:0] pos);
        list_op_t it;
        it.op = op;
        it.key = key;
        it.new_value = nv;
        it.position = pos;
        pending_ops.push_back(it);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    // driver: offers the pending items with a random wait before each one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            send_wait = 0;
        end else begin
            offered = s_tvalid;
            if (s_tvalid && s_tready) begin
                expected_results.push_back(apply_op(cur_item));
                items_accepted++;
                offered = 1'b0;
            end
            if (!offered) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (pending_ops.size() > 0) begin
                    cur_item = pending_ops.pop_front();
                    offered = 1'b1;
                    if ($urandom_range(0, 24) == 0)
                        send_burst = !send_burst;
                    send_wait = draw_wait(send_burst);
                end
            end
            s_tvalid <= offered;
            s_tdata <= {2'b00, cur_item.position, cur_item.new_value, cur_item.key};
            s_tuser <= cur_item.op;
        end
    end

    // monitor: checks each result item against the oldest expectation
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.status = m_tuser;
                got.found_index = m_tdata[5:0];
                got.popped_value = m_tdata[37:6];
                got.entry_total = m_tdata[44:38];
                if (expected_results.size() == 0) begin
                    $error("result item with no expectation waiting");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("found_index", 32'(want.found_index),
                                32'(got.found_index));
                    check_field("popped_value", want.popped_value, got.popped_value);
                    check_field("entry_total", 32'(want.entry_total),
                                32'(got.entry_total));
                    status_seen[want.status]++;
                    if (int'(want.entry_total) > peak_total)
                        peak_total = int'(want.entry_total);
                end
                results_checked++;
                if ($urandom_range(0, 24) == 0)
                    recv_burst = !recv_burst;
                recv_wait = draw_wait(recv_burst);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // stimulus, reset and end of run
    initial begin
        mix_t mix;
        int   phase_left;
        phase_left = 0;
        mix = PH_FILL;

        // directed: empty store, extremes, duplicates, misses, range limits, spare codes
        queue_op(OP_POP, 32'h0, 32'h0, 6'd0);
        queue_op(OP_SWAP, 32'h0, 32'h0, 6'd0);
        queue_op(OP_REPLACE, 32'h0, 32'h1, 6'd0);
        queue_op(OP_SPARE_A, 32'h1357_9BDF, 32'h2468_ACE0, 6'd21);
        queue_op(OP_ADD_UNIQUE, 32'h8000_0000, 32'h0, 6'd0);
        queue_op(OP_ADD_UNIQUE, 32'h7FFF_FFFF, 32'h0, 6'd0);
        queue_op(OP_ADD_UNIQUE, 32'h8000_0000, 32'h0, 6'd0);
        queue_op(OP_APPEND, 32'h7FFF_FFFF, 32'h0, 6'd0);
        queue_op(OP_APPEND, 32'h0, 32'h0, 6'd0);
        queue_op(OP_ADD_UNIQUE, 32'hFFFF_FFFF, 32'h0, 6'd0);
        queue_op(OP_REPLACE, 32'h7FFF_FFFF, 32'h1234_5678, 6'd0);
        queue_op(OP_REPLACE, 32'h0000_0005, 32'hFFFF_FFFF, 6'd0);
        queue_op(OP_SWAP, 32'hFFFF_FFFF, 32'h0, 6'd0);
        queue_op(OP_SWAP, 32'h5555_5555, 32'h0, 6'd1);
        queue_op(OP_SWAP, 32'h0, 32'h0, 6'd63);
        queue_op(OP_SWAP, 32'h0, 32'h0, 6'd5);
        queue_op(OP_SWAP, 32'h0, 32'h0, 6'd4);
        queue_op(OP_SPARE_B, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
        queue_op(OP_POP, 32'h0, 32'h0, 6'd0);
        queue_op(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
        queue_op(OP_POP, 32'h0, 32'h0, 6'd0);
        queue_op(OP_APPEND, 32'hAAAA_AAAA, 32'h5555_5555, 6'd42);

        // random: phases that fill, drain or mix, starting with a fill to reach full
        while (pending_ops.size() < TOTAL_ITEMS) begin
            if (phase_left == 0) begin
                if (pending_ops.size() > 30)
                    mix = mix_t'($urandom_range(0, 2));
                phase_left = $urandom_range(40, 100);
            end
            queue_op(pick_op(mix), pick_value(),
                     ($urandom_range(0, 1) == 0) ? pick_value() : $urandom,
                     pick_position());
            phase_left--;
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // an item taken from the queue counts as pending until it is accepted
        while (pending_ops.size() > 0 || offered || s_tvalid ||
               expected_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d items, %0d results, peak count %0d of %0d", items_accepted,
                 results_checked, peak_total, LIST_DEPTH);
        $display("refused: full %0d, empty %0d, duplicate %0d, miss %0d, bad position %0d",
                 status_seen[ST_FULL], status_seen[ST_EMPTY], status_seen[ST_PRESENT],
                 status_seen[ST_NOT_FOUND], status_seen[ST_BAD_POS]);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ bounded_list_store.f @@
src/bls_pkg.sv
src/bls_mem.sv
src/bls_ctrl.sv
src/bounded_list_store.sv
src/bls_checker.sv
tb/bounded_list_store_test.sv
